// ===== sv/ctach_pkg.sv =====
// Shared types and constants for the capture tachometer.
// Used by the front end, the command queue, the divider back end and the top level.
`default_nettype none

package ctach_pkg;

    localparam int WEIGHT_W   = 8;
    localparam int NUMER_W    = 24;
    localparam int TIMEOUT_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CAPTURE_W  = 16;
    localparam int COUNT_W    = 16;
    localparam int PERIOD_W   = 24;
    localparam int SPEED_W    = 16;

    localparam int FIFO_DEPTH = 2;

    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET  = 8'd50;
    localparam logic [NUMER_W-1:0]   NUMER_RESET   = 24'd600000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 4'd2;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERFLOW_WEIGHT     = 2'd0,
        REG_RPM_NUMERATOR       = 2'd1,
        REG_ZERO_TIMEOUT_RELOAD = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_EDGE     = 2'd0,
        MODE_OVERFLOW = 2'd1,
        MODE_TICK     = 2'd2,
        MODE_REARM    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_KEEP   = 2'd0,
        OP_ZERO   = 2'd1,
        OP_DIVIDE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [PERIOD_W-1:0] period;
        logic                done;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/ctach_front.sv =====
// Front end: accepts input items, keeps the edge and timeout state and turns
// each item into one speed command for the back end. Depends on ctach_pkg.
`default_nettype none

module ctach_front
    import ctach_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_mode,
    input  wire logic [CAPTURE_W-1:0] s_capture_value,
    input  wire logic                 s_running,
    input  wire logic [WEIGHT_W-1:0]  overflow_weight,
    input  wire logic [TIMEOUT_W-1:0] zero_timeout_reload,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    logic [COUNT_W-1:0]   ovf_count_reg, ovf_count_next;
    logic                 first_reg, first_next;
    logic                 counting_reg, counting_next;
    logic                 done_reg, done_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [TIMEOUT_W-1:0] timeout_dec;
    logic [PERIOD_W-1:0]  period;
    op_t                  op;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Fits in 24 bits: 65535 * 255 + 65535 < 2^24.
    assign period = PERIOD_W'(ovf_count_reg * overflow_weight)
                  + PERIOD_W'(s_capture_value);

    assign timeout_dec = (timeout_reg != '0) ? timeout_reg - 1'b1 : '0;

    always_comb begin
        ovf_count_next = ovf_count_reg;
        first_next     = first_reg;
        counting_next  = counting_reg;
        done_next      = done_reg;
        timeout_next   = timeout_reg;
        op             = OP_KEEP;
        unique case (mode_t'(s_mode))
            MODE_EDGE: begin
                // Edges count only while the motor runs and no result is held.
                if (s_running && !done_reg) begin
                    timeout_next = zero_timeout_reload;
                    if (first_reg) begin
                        done_next     = 1'b1;
                        first_next    = 1'b0;
                        counting_next = 1'b0;
                        op            = OP_DIVIDE;
                    end else begin
                        ovf_count_next = '0;
                        first_next     = 1'b1;
                        counting_next  = 1'b1;
                    end
                end
            end
            MODE_OVERFLOW: begin
                if (counting_reg) begin
                    ovf_count_next = ovf_count_reg + 1'b1;
                end
            end
            MODE_TICK: begin
                timeout_next = timeout_dec;
                if (timeout_dec == '0) begin
                    op = OP_ZERO;
                end
            end
            MODE_REARM: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        q_cmd.op     = op;
        q_cmd.period = period;
        q_cmd.done   = done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_count_reg <= '0;
            first_reg     <= 1'b0;
            counting_reg  <= 1'b0;
            done_reg      <= 1'b0;
            timeout_reg   <= '0;
        end else if (q_push) begin
            ovf_count_reg <= ovf_count_next;
            first_reg     <= first_next;
            counting_reg  <= counting_next;
            done_reg      <= done_next;
            timeout_reg   <= timeout_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ctach_fifo.sv =====
// Short command queue between the front end and the divider back end.
// Depends on ctach_pkg for the command type.
`default_nettype none

module ctach_fifo
    import ctach_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output cmd_t      head
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ctach_back.sv =====
// Back end: executes speed commands in order, runs the bit-serial divider for
// a finished measurement and holds the result register. Depends on ctach_pkg.
`default_nettype none

module ctach_back
    import ctach_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire cmd_t               q_cmd,
    output logic                    q_pop,
    input  wire logic [NUMER_W-1:0] rpm_numerator,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [SPEED_W-1:0]      m_speed_rpm,
    output logic                    m_measure_done
);

    localparam int StepW = $clog2(PERIOD_W + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t              state_reg;
    logic [StepW-1:0]    step_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [NUMER_W-1:0]  quot_reg;
    logic [PERIOD_W-1:0] divisor_reg;
    logic                done_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic                m_valid_reg;
    logic [SPEED_W-1:0]  m_speed_reg;
    logic                m_done_reg;

    logic                out_free;
    logic                out_load;
    logic [PERIOD_W:0]   rem_shift;
    logic                rem_ge;
    logic [SPEED_W-1:0]  quot_sat;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;

    // A result is loaded by every popped command except a division that has to run.
    assign out_load = (q_pop && !(q_cmd.op == OP_DIVIDE && q_cmd.period != '0))
                   || ((state_reg == ST_DIV) && (step_reg == '0) && out_free);

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, quot_reg[NUMER_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign quot_sat  = (quot_reg[NUMER_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                           : quot_reg[SPEED_W-1:0];

    assign m_valid        = m_valid_reg;
    assign m_speed_rpm    = m_speed_reg;
    assign m_measure_done = m_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            speed_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_speed_reg <= '0;
            m_done_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        case (q_cmd.op)
                            OP_DIVIDE: begin
                                if (q_cmd.period == '0) begin
                                    speed_reg   <= SPEED_MAX;
                                    m_speed_reg <= SPEED_MAX;
                                    m_done_reg  <= q_cmd.done;
                                end else begin
                                    rem_reg     <= '0;
                                    quot_reg    <= rpm_numerator;
                                    divisor_reg <= q_cmd.period;
                                    done_reg    <= q_cmd.done;
                                    step_reg    <= StepW'(PERIOD_W);
                                    state_reg   <= ST_DIV;
                                end
                            end
                            OP_ZERO: begin
                                speed_reg   <= '0;
                                m_speed_reg <= '0;
                                m_done_reg  <= q_cmd.done;
                            end
                            default: begin
                                m_speed_reg <= speed_reg;
                                m_done_reg  <= q_cmd.done;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (step_reg != '0) begin
                        if (rem_ge) begin
                            rem_reg <= PERIOD_W'(rem_shift - {1'b0, divisor_reg});
                        end else begin
                            rem_reg <= rem_shift[PERIOD_W-1:0];
                        end
                        quot_reg <= {quot_reg[NUMER_W-2:0], rem_ge};
                        step_reg <= step_reg - 1'b1;
                    end else if (out_free) begin
                        speed_reg   <= quot_sat;
                        m_speed_reg <= quot_sat;
                        m_done_reg  <= done_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/capture_tachometer.sv =====
// Capture tachometer top level: configuration registers, front end, command
// queue and divider back end. Depends on ctach_pkg and the ctach_* modules.
//
// Usage:
//   Input channel (s_valid/s_ready): one event per transfer. s_mode selects a
//   capture edge, a timer overflow, a timeout tick or a rearm. s_capture_value
//   and s_running are used on capture edges only.
//   Result channel (m_valid/m_ready): exactly one result per input transfer, in
//   order, giving the speed and the measurement-done flag after that event.
//   Configuration: a write at cfg_index with cfg_wr_en high takes effect at that
//   clock edge; write only while no event is in flight.
// Ordering and throughput:
//   Each event passes the queue and the back end registers its result; the
//   second capture edge of a measurement first runs the 24-step serial divider,
//   unless its period is zero. The divider is the only multi-cycle unit, so events
//   are taken at one per cycle while the queue is not full, and a queue of
//   FIFO_DEPTH commands lets the front end keep taking events meanwhile.
// Reset and stalls:
//   Synchronous active-low reset clears all measurement state, the speed and
//   the queue and restores the register defaults. When m_ready is low the
//   result holds; the queue fills and s_ready then drops.
`default_nettype none

module capture_tachometer
    import ctach_pkg::*;
#(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [CAPTURE_W-1:0]  s_capture_value,
    input  wire logic                  s_running,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [SPEED_W-1:0]         m_speed_rpm,
    output logic                       m_measure_done,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [WEIGHT_W-1:0]  weight_reg;
    logic [NUMER_W-1:0]   numer_reg;
    logic [TIMEOUT_W-1:0] reload_reg;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;
    cmd_t q_in;
    cmd_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            numer_reg  <= NUMER_RESET;
            reload_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OVERFLOW_WEIGHT:     weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                REG_RPM_NUMERATOR:       numer_reg  <= cfg_wdata[NUMER_W-1:0];
                REG_ZERO_TIMEOUT_RELOAD: reload_reg <= cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    ctach_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_capture_value     (s_capture_value),
        .s_running           (s_running),
        .overflow_weight     (weight_reg),
        .zero_timeout_reload (reload_reg),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_cmd               (q_in)
    );

    ctach_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ctach_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_cmd          (q_head),
        .q_pop          (q_pop),
        .rpm_numerator  (numer_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_speed_rpm    (m_speed_rpm),
        .m_measure_done (m_measure_done)
    );

endmodule

`default_nettype wire

// ===== dv/capture_tachometer_tb.sv =====
// Self-checking testbench for capture_tachometer: directed table, then random
// measurement sequences under several register settings. Depends on ctach_pkg.
// A behavioral predictor models the tachometer state and checks every result in order.
module capture_tachometer_tb;
    import ctach_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int MAX_REPORTS = 10;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               done;
    } tach_result_t;

    typedef struct packed {
        mode_t                mode;
        logic [CAPTURE_W-1:0] cap;
        logic                 run;
        logic                 typed;
        logic [SPEED_W-1:0]   speed;
        logic                 done;
    } tach_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    mode_t                 s_mode = MODE_TICK;
    logic [CAPTURE_W-1:0]  s_capture_value = '0;
    logic                  s_running = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [SPEED_W-1:0]    m_speed_rpm;
    logic                  m_measure_done;
    logic                  cfg_wr_en = 1'b0;
    reg_idx_t              cfg_index = REG_OVERFLOW_WEIGHT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Typed expectation that travels with the item currently offered.
    logic                  row_typed = 1'b0;
    logic [SPEED_W-1:0]    row_speed = '0;
    logic                  row_done = 1'b0;
    logic                  next_typed = 1'b0;
    logic [SPEED_W-1:0]    next_speed = '0;
    logic                  next_done = 1'b0;

    bit idle_on = 1'b1;

    // Predictor copy of the registers and measurement state.
    logic [WEIGHT_W-1:0]  cfg_weight = WEIGHT_RESET;
    logic [NUMER_W-1:0]   cfg_numer = NUMER_RESET;
    logic [TIMEOUT_W-1:0] cfg_reload = TIMEOUT_RESET;
    logic [COUNT_W-1:0]   ovf_count = '0;
    logic                 first_seen = 1'b0;
    logic                 counting = 1'b0;
    logic                 meas_done = 1'b0;
    logic [TIMEOUT_W-1:0] tmo_left = '0;
    logic [SPEED_W-1:0]   speed_now = '0;

    tach_result_t speed_readings_q[$];

    int n_items = 0;
    int n_results = 0;
    int n_measured = 0;
    int n_saturated = 0;
    int n_forced_zero = 0;
    int n_errors = 0;

    tach_row_t dir_rows [0:N_DIRECTED-1];

    capture_tachometer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_capture_value (s_capture_value),
        .s_running       (s_running),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed_rpm     (m_speed_rpm),
        .m_measure_done  (m_measure_done),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("FAIL capture_tachometer");
        $finish;
    end

    // Applies one event to the predicted state and returns the speed and done flag after it.
    function automatic tach_result_t advance_tachometer(mode_t mode, logic [CAPTURE_W-1:0] cap,
                                                        logic run);
        tach_result_t res;
        logic [31:0] period;
        logic [31:0] quot;
        case (mode)
            MODE_EDGE: begin
                if (run && !meas_done) begin
                    tmo_left = cfg_reload;
                    if (first_seen) begin
                        meas_done = 1'b1;
                        first_seen = 1'b0;
                        counting = 1'b0;
                        period = 32'(ovf_count) * 32'(cfg_weight) + 32'(cap);
                        quot = (period == 0) ? 32'hFFFF_FFFF : 32'(cfg_numer) / period;
                        n_measured++;
                        if (quot > 32'd65535) begin
                            speed_now = SPEED_MAX;
                            n_saturated++;
                        end else begin
                            speed_now = quot[SPEED_W-1:0];
                        end
                    end else begin
                        ovf_count = '0;
                        first_seen = 1'b1;
                        meas_done = 1'b0;
                        counting = 1'b1;
                    end
                end
            end
            MODE_OVERFLOW: begin
                if (counting)
                    ovf_count = ovf_count + 1'b1;
            end
            MODE_TICK: begin
                if (tmo_left != 0)
                    tmo_left = tmo_left - 1'b1;
                if (tmo_left == 0) begin
                    if (speed_now != 0)
                        n_forced_zero++;
                    speed_now = '0;
                end
            end
            default: begin
                meas_done = 1'b0;
            end
        endcase
        res.speed = speed_now;
        res.done = meas_done;
        return res;
    endfunction

    // Results are popped before new expectations are pushed, so a result that
    // arrives with nothing pending is never hidden by a transfer in the same cycle.
    always @(posedge aclk) begin
        tach_result_t want;
        tach_result_t got;
        tach_result_t pred;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OVERFLOW_WEIGHT:     cfg_weight = cfg_wdata[WEIGHT_W-1:0];
                    REG_RPM_NUMERATOR:       cfg_numer = cfg_wdata[NUMER_W-1:0];
                    REG_ZERO_TIMEOUT_RELOAD: cfg_reload = cfg_wdata[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.speed = m_speed_rpm;
                got.done = m_measure_done;
                n_results++;
                if (speed_readings_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: result with nothing pending: speed %0d done %0b",
                                 got.speed, got.done);
                end else begin
                    want = speed_readings_q.pop_front();
                    if (got.speed !== want.speed || got.done !== want.done) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"ERROR: result %0d: expected speed %0d done %0b, ",
                                      "got speed %0d done %0b"},
                                     n_results, want.speed, want.done, got.speed, got.done);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = advance_tachometer(s_mode, s_capture_value, s_running);
                if (row_typed) begin
                    pred.speed = row_speed;
                    pred.done = row_done;
                end
                speed_readings_q.push_back(pred);
                n_items++;
            end
        end
    end

    // Result side back-pressure in random bursts.
    initial begin
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // Offers one event and returns at the clock edge where the transfer happens.
    task automatic send_event(mode_t mode, logic [CAPTURE_W-1:0] cap, logic run);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_capture_value <= cap;
        s_running <= run;
        row_typed <= next_typed;
        row_speed <= next_speed;
        row_done <= next_done;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds off the sender until every pending result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (speed_readings_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] weight, logic [CFG_DATA_W-1:0] numer,
                                 logic [CFG_DATA_W-1:0] reload);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OVERFLOW_WEIGHT;
        cfg_wdata <= weight;
        @(posedge aclk);
        cfg_index <= REG_RPM_NUMERATOR;
        cfg_wdata <= numer;
        @(posedge aclk);
        cfg_index <= REG_ZERO_TIMEOUT_RELOAD;
        cfg_wdata <= reload;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly complete measurements (rearm, a start and a stop capture edge with overflows between,
    // a few ticks), with some ignored edges and random noise mixed in.
    task automatic run_random_phase(int n_seq);
        int n_ovf;
        logic [CAPTURE_W-1:0] cap;
        repeat (n_seq) begin
            if ($urandom_range(0, 9) < 7) begin
                send_event(MODE_REARM, CAPTURE_W'($urandom), 1'($urandom));
                send_event(MODE_EDGE, CAPTURE_W'($urandom), 1'b1);
                n_ovf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 6);
                repeat (n_ovf) send_event(MODE_OVERFLOW, CAPTURE_W'($urandom), 1'($urandom));
                if ($urandom_range(0, 3) == 0)
                    send_event(MODE_EDGE, CAPTURE_W'($urandom), 1'b0);
                cap = ($urandom_range(0, 3) == 0) ? CAPTURE_W'($urandom_range(0, 15))
                                                  : CAPTURE_W'($urandom);
                send_event(MODE_EDGE, cap, 1'b1);
                repeat ($urandom_range(0, 3)) send_event(MODE_TICK, CAPTURE_W'($urandom),
                                                         1'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_event(mode_t'($urandom_range(0, 3)), CAPTURE_W'($urandom),
                               1'($urandom));
            end
        end
    endtask

    initial begin
        dir_rows = '{
            '{MODE_TICK,     16'h0000, 1'b1, 1'b1, 16'd0,     1'b0},
            '{MODE_OVERFLOW, 16'h0000, 1'b0, 1'b1, 16'd0,     1'b0},
            '{MODE_EDGE,     16'h1234, 1'b0, 1'b1, 16'd0,     1'b0},
            '{MODE_EDGE,     16'h0000, 1'b1, 1'b1, 16'd0,     1'b0},
            '{MODE_OVERFLOW, 16'h0000, 1'b1, 1'b0, 16'd0,     1'b0},
            '{MODE_OVERFLOW, 16'hFFFF, 1'b0, 1'b0, 16'd0,     1'b0},
            '{MODE_OVERFLOW, 16'h0000, 1'b1, 1'b0, 16'd0,     1'b0},
            '{MODE_EDGE,     16'h0000, 1'b1, 1'b1, 16'd4000,  1'b1},
            '{MODE_EDGE,     16'h0050, 1'b1, 1'b1, 16'd4000,  1'b1},
            '{MODE_TICK,     16'h0000, 1'b0, 1'b1, 16'd4000,  1'b1},
            '{MODE_REARM,    16'hFFFF, 1'b1, 1'b1, 16'd4000,  1'b0},
            '{MODE_EDGE,     16'hFFFF, 1'b1, 1'b1, 16'd4000,  1'b0},
            '{MODE_EDGE,     16'h0000, 1'b1, 1'b1, 16'd65535, 1'b1},
            '{MODE_REARM,    16'h0000, 1'b0, 1'b1, 16'd65535, 1'b0},
            '{MODE_EDGE,     16'h0000, 1'b1, 1'b1, 16'd65535, 1'b0},
            '{MODE_EDGE,     16'h0001, 1'b1, 1'b1, 16'd65535, 1'b1},
            '{MODE_TICK,     16'hFFFF, 1'b1, 1'b1, 16'd65535, 1'b1},
            '{MODE_TICK,     16'h0000, 1'b0, 1'b1, 16'd0,     1'b1},
            '{MODE_TICK,     16'h0000, 1'b1, 1'b1, 16'd0,     1'b1},
            '{MODE_REARM,    16'h0000, 1'b0, 1'b1, 16'd0,     1'b0},
            '{MODE_EDGE,     16'h0000, 1'b1, 1'b0, 16'd0,     1'b0},
            '{MODE_EDGE,     16'hFFFF, 1'b1, 1'b1, 16'd9,     1'b1},
            '{MODE_EDGE,     16'h0001, 1'b0, 1'b1, 16'd9,     1'b1}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows run with the reset register values.
        for (int i = 0; i < N_DIRECTED; i++) begin
            next_typed = dir_rows[i].typed;
            next_speed = dir_rows[i].speed;
            next_done = dir_rows[i].done;
            send_event(dir_rows[i].mode, dir_rows[i].cap, dir_rows[i].run);
        end
        next_typed = 1'b0;

        load_settings(24'd1, 24'd1, 24'd1);
        run_random_phase(10);
        load_settings(24'd255, 24'hFFFFFF, 24'd15);
        run_random_phase(10);
        load_settings(24'd0, 24'd0, 24'd0);
        run_random_phase(10);
        load_settings(24'($urandom_range(1, 255)), 24'($urandom_range(1, 24'hFFFFFF)),
                      24'($urandom_range(1, 15)));
        run_random_phase(10);
        // Unused upper data bits are set here; each register keeps only its width.
        load_settings(24'($urandom), 24'($urandom), 24'($urandom));
        run_random_phase(10);

        idle_on = 1'b0;

        load_settings(24'(WEIGHT_RESET), 24'(NUMER_RESET), 24'(TIMEOUT_RESET));
        run_random_phase(10);
        wait_for_results();

        $display("Run covered %0d transfers in, %0d results checked, %0d errors.",
                 n_items, n_results, n_errors);
        $display("Measurements completed: %0d, saturated speeds: %0d, timeouts to zero: %0d.",
                 n_measured, n_saturated, n_forced_zero);
        if (n_errors == 0) begin
            $display("PASS capture_tachometer");
        end else begin
            $display("FAIL capture_tachometer");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ctach_pkg.sv
sv/ctach_front.sv
sv/ctach_fifo.sv
sv/ctach_back.sv
sv/capture_tachometer.sv
dv/capture_tachometer_tb.sv
